[design/pfa_pkg.sv]
// pfa_pkg: shared types, codes and constants of the partition fit allocator
// used by pfa_ctrl, pfa_datapath and partition_fit_allocator_top; no dependencies
package pfa_pkg;

   // default number of partitions held
   localparam int NUM_BLOCKS_DEF = 64;

   // field widths
   localparam int SLOT_W  = 6;
   localparam int SIZE_W  = 16;
   localparam int FREE_W  = 22;
   localparam int MODE_W  = 2;
   localparam int COUNT_W = 7;
   localparam int CSR_W   = 7;

   // saturation value of the free total
   localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

   // item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // placement policies
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // register indexes
   localparam logic CSR_FIT_MODE    = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic              op;
      logic [SLOT_W-1:0] block_slot;
      logic [SIZE_W-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] chosen_block;
      logic [FREE_W-1:0] free_space;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic load_write;
      logic scan_step;
      logic commit;
      logic rsp_load;
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic in_alloc;
      logic scan_done;
      logic rsp_free;
   } ctl_status_type;

endpackage

[design/pfa_ctrl.sv]
// pfa_ctrl: sequencing state machine of the partition fit allocator
// depends on pfa_pkg; drives pfa_datapath through command and status structs
module pfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pfa_pkg::ctl_status_type status,
   output pfa_pkg::ctl_cmd_type    cmd
);

   pfa_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.in_alloc ? pfa_pkg::ST_SCAN : pfa_pkg::ST_LOAD;
            end
         end
         pfa_pkg::ST_LOAD: begin
            state_in = pfa_pkg::ST_FINISH;
         end
         pfa_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = pfa_pkg::ST_COMMIT;
            end
         end
         pfa_pkg::ST_COMMIT: begin
            state_in = pfa_pkg::ST_FINISH;
         end
         pfa_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = pfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         pfa_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
         end
         pfa_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         pfa_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         pfa_pkg::ST_FINISH: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[design/pfa_datapath.sv]
// pfa_datapath: size memory, taken marks, free total, scan unit and result register
// depends on pfa_pkg; commanded by pfa_ctrl
module pfa_datapath #(
   parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pfa_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pfa_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [pfa_pkg::CSR_W-1:0]      csr_wdata,
   input  pfa_pkg::ctl_cmd_type           cmd,
   output pfa_pkg::ctl_status_type        status
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W = (CNT_W > pfa_pkg::COUNT_W) ? CNT_W : pfa_pkg::COUNT_W;

   // configuration registers
   logic [pfa_pkg::MODE_W-1:0]  fit_mode_ff;
   logic [pfa_pkg::COUNT_W-1:0] block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= pfa_pkg::FIT_FIRST;
         block_count_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            pfa_pkg::CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[pfa_pkg::MODE_W-1:0];
            pfa_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[pfa_pkg::COUNT_W-1:0];
            default:                  fit_mode_ff    <= fit_mode_ff;
         endcase
      end
   end

   // captured item
   pfa_pkg::req_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   // scan limit is the smaller of block_count and the table depth
   logic [LIM_W-1:0] count_ext;
   logic [LIM_W-1:0] depth_ext;
   logic [CNT_W-1:0] limit;

   assign count_ext = LIM_W'(block_count_ff);
   assign depth_ext = LIM_W'(NUM_BLOCKS);
   assign limit     = CNT_W'((count_ext > depth_ext) ? depth_ext : count_ext);

   // load write address and range check
   logic             slot_ok;
   logic [IDX_W-1:0] wr_idx;

   assign slot_ok = (32'(item_ff.block_slot) < 32'(NUM_BLOCKS));
   assign wr_idx  = IDX_W'(item_ff.block_slot);

   // scan read issue
   logic [CNT_W-1:0] rd_cnt_ff;
   logic             issue;

   assign issue = cmd.scan_step && (rd_cnt_ff < limit);

   // size memory with registered read
   logic [pfa_pkg::SIZE_W-1:0] size_mem [NUM_BLOCKS];
   logic [pfa_pkg::SIZE_W-1:0] rd_size_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         size_mem[wr_idx] <= item_ff.size_value;
      end
      if (issue) begin
         rd_size_ff <= size_mem[rd_cnt_ff[IDX_W-1:0]];
      end
   end

   // taken marks, read alongside the size
   logic [NUM_BLOCKS-1:0] taken_ff;
   logic                  rd_taken_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic                  found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
      end else if (cmd.load_write && slot_ok) begin
         taken_ff[wr_idx] <= 1'b0;
      end else if (cmd.commit && found_ff) begin
         taken_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_taken_ff <= taken_ff[rd_cnt_ff[IDX_W-1:0]];
      end
   end

   // scan pipeline control
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_cnt_ff <= '0;
      end else if (issue) begin
         rd_cnt_ff <= rd_cnt_ff + 1'b1;
      end
      if (issue) begin
         cmp_idx_ff <= rd_cnt_ff[IDX_W-1:0];
      end
   end

   // compare stage: candidate check and policy
   logic [pfa_pkg::SIZE_W-1:0] best_size_ff;
   logic                       fits;
   logic                       better;
   logic                       take;

   assign fits = cmp_vld_ff && !rd_taken_ff && (rd_size_ff >= item_ff.size_value);

   always_comb begin
      case (fit_mode_ff)
         pfa_pkg::FIT_BEST:  better = (rd_size_ff < best_size_ff);
         pfa_pkg::FIT_WORST: better = (rd_size_ff > best_size_ff);
         default:            better = 1'b0;
      endcase
   end

   assign take = fits && (!found_ff || better);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff     <= 1'b1;
         best_idx_ff  <= cmp_idx_ff;
         best_size_ff <= rd_size_ff;
      end
   end

   // free total: saturating add on load, floored subtract on grant
   logic [pfa_pkg::FREE_W-1:0] free_total_ff;
   logic [pfa_pkg::FREE_W:0]   free_sum;
   logic [pfa_pkg::FREE_W-1:0] req_ext;

   assign free_sum = {1'b0, free_total_ff} + (pfa_pkg::FREE_W + 1)'(item_ff.size_value);
   assign req_ext  = pfa_pkg::FREE_W'(item_ff.size_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_total_ff <= '0;
      end else if (cmd.load_write && slot_ok) begin
         free_total_ff <= free_sum[pfa_pkg::FREE_W] ? pfa_pkg::FREE_MAX
                                                    : free_sum[pfa_pkg::FREE_W-1:0];
      end else if (cmd.commit && found_ff) begin
         free_total_ff <= (free_total_ff >= req_ext) ? (free_total_ff - req_ext) : '0;
      end
   end

   // result register
   pfa_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic             grant;

   assign grant = (item_ff.op == pfa_pkg::OP_ALLOC) && found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.granted      <= grant;
         rsp_ff.chosen_block <= grant ? pfa_pkg::SLOT_W'(best_idx_ff) : '0;
         rsp_ff.free_space   <= free_total_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to controller
   assign status.in_alloc  = (req_data.op == pfa_pkg::OP_ALLOC);
   assign status.scan_done = !issue && !cmp_vld_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

endmodule

[design/partition_fit_allocator_top.sv]
// partition_fit_allocator_top: top level of the fixed-partition fit allocator
// depends on pfa_pkg, pfa_ctrl and pfa_datapath
//
// Usage: items arrive on the req_ channel (valid/ready) as a load (op 0:
// write a partition size, clear its taken mark, add to the free total) or an
// allocate (op 1: request a size). Each item gives one result on the rsp_
// channel: grant flag, chosen partition and free total after the item.
// fit_mode and block_count are set on the csr_ write port while idle.
// A load is written in the load step, then its result is registered in the
// finish step. An allocate scans min(block_count, NUM_BLOCKS) partitions:
// the scan reads the size memory one partition per cycle through its single
// registered read port, then the commit step marks the choice taken. One item
// is in work at a time; req_ready is high only between items, so a new item
// is taken only after the last one has left the finish step.
// Reset (synchronous, active high) clears all taken marks, the free total
// and both registers; partition sizes are undefined until loaded.
// A stalled receiver: the result waits in the output register while the
// next item is taken and worked; that item's result holds in the finish
// step until the output register is free.
module partition_fit_allocator_top #(
   parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pfa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pfa_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [pfa_pkg::CSR_W-1:0] csr_wdata
);

   pfa_pkg::ctl_cmd_type    cmd;
   pfa_pkg::ctl_status_type status;

   // sequencer
   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, scan and result
   pfa_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
